// File: sv/prac_pkg.sv
package prac_pkg;

    // Fixed field widths
    localparam int PAGE_IN_W = 4;
    localparam int FRAME_W   = 5;
    localparam int FAULT_W   = 16;

    localparam logic [FRAME_W-1:0] FRAME_COUNT_RESET = 5'd5;
    localparam logic [FAULT_W-1:0] FAULT_MAX         = 16'hFFFF;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_SCAN_END,
        S_VREAD,
        S_EVICT,
        S_DONE
    } prac_state_t;

    // Control for the minimum-count scan unit
    typedef struct packed {
        logic clear;    // start a new search
        logic sample;   // a counter tap is present this cycle
    } scan_ctl_t;

endpackage

// File: sv/prac_min_scan.sv
module prac_min_scan
    import prac_pkg::*;
#(
    parameter int PAGE_W      = 4,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  scan_ctl_t              ctl,
    input  logic [PAGE_W-1:0]      tap_idx,
    input  logic [COUNT_WIDTH-1:0] tap_count,
    input  logic                   tap_resident,
    output logic                   best_valid,
    output logic [PAGE_W-1:0]      best_idx
);

    logic                   best_valid_reg;
    logic                   best_valid_next;
    logic [PAGE_W-1:0]      best_idx_reg;
    logic [PAGE_W-1:0]      best_idx_next;
    logic [COUNT_WIDTH-1:0] best_count_reg;
    logic [COUNT_WIDTH-1:0] best_count_next;
    logic                   take;

    // One compare per tap; strict less-than keeps the lowest index on ties
    assign take = ctl.sample && tap_resident &&
                  (!best_valid_reg || (tap_count < best_count_reg));

    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_count_next = best_count_reg;
        if (ctl.clear)
        begin
            best_valid_next = 1'b0;
        end
        else if (take)
        begin
            best_valid_next = 1'b1;
            best_idx_next   = tap_idx;
            best_count_next = tap_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
        end
        else
        begin
            best_valid_reg <= best_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_count_reg <= best_count_next;
    end

    assign best_valid = best_valid_reg;
    assign best_idx   = best_idx_reg;

endmodule

// File: sv/page_replacement_access_count.sv
// Channel | Dir | Handshake              | Word
// --------+-----+------------------------+-------------------------------------------
// cfg     | in  | cfg_valid / cfg_ready  | cfg_data (frame_count)
// in      | in  | in_valid / in_ready    | page
// out     | out | out_valid / out_ready  | hit, frame, evicted_valid, evicted_page,
//         |     |                        | faults_so_far
//
// Hit or free-frame miss: IDLE, LOOKUP, DONE; out-of-range page: IDLE, DONE.
// Miss with eviction: LOOKUP, SCAN, SCAN_END, VREAD, EVICT, DONE; the count RAM
// read port walks every page once and one comparator tracks the minimum.
// One word in flight; in_ready is high only in the idle state.
// A finished result waits in the output register; a new word is accepted meanwhile.
// Reset clears resident bits, frame allocation and fault total; frame_count
// returns to 5. cfg_ready is always high.
module page_replacement_access_count
    import prac_pkg::*;
#(
    parameter int NUM_PAGES   = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [FRAME_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_IN_W-1:0] page,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [FRAME_W-1:0]   frame,
    output logic                 evicted_valid,
    output logic [PAGE_IN_W-1:0] evicted_page,
    output logic [FAULT_W-1:0]   faults_so_far
);

    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

    prac_state_t state_reg;
    prac_state_t state_next;

    // Control registers
    logic [FRAME_W-1:0]   frame_count_reg;
    logic [FRAME_W-1:0]   frames_given_reg;
    logic [FRAME_W-1:0]   frames_given_next;
    logic [FAULT_W-1:0]   fault_total_reg;
    logic [FAULT_W-1:0]   fault_total_next;
    logic [NUM_PAGES-1:0] resident_reg;
    logic [NUM_PAGES-1:0] resident_next;
    logic                 cmp_valid_reg;
    logic                 cmp_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // Payload registers
    logic [PAGE_W-1:0]    page_reg;
    logic [PAGE_W-1:0]    page_next;
    logic [PAGE_W-1:0]    scan_idx_reg;
    logic [PAGE_W-1:0]    scan_idx_next;
    logic [PAGE_W-1:0]    cmp_idx_reg;
    logic [PAGE_W-1:0]    cmp_idx_next;
    logic                 res_hit_reg;
    logic                 res_hit_next;
    logic [FRAME_W-1:0]   res_frame_reg;
    logic [FRAME_W-1:0]   res_frame_next;
    logic                 res_ev_valid_reg;
    logic                 res_ev_valid_next;
    logic [PAGE_IN_W-1:0] res_ev_page_reg;
    logic [PAGE_IN_W-1:0] res_ev_page_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [FRAME_W-1:0]   frame_reg;
    logic [FRAME_W-1:0]   frame_next;
    logic                 evicted_valid_reg;
    logic                 evicted_valid_next;
    logic [PAGE_IN_W-1:0] evicted_page_reg;
    logic [PAGE_IN_W-1:0] evicted_page_next;
    logic [FAULT_W-1:0]   faults_reg;
    logic [FAULT_W-1:0]   faults_next;

    // Memories: use counter and frame per page
    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_PAGES];
    logic [FRAME_W-1:0]     frm_mem [NUM_PAGES];
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [FRAME_W-1:0]     frm_rd_reg;
    logic [PAGE_W-1:0]      cnt_ra;
    logic [PAGE_W-1:0]      frm_ra;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wd;
    logic                   frm_we;
    logic [FRAME_W-1:0]     frm_wd;

    // Misc
    logic [PAGE_W-1:0]    page_idx_in;
    logic                 in_range;
    logic                 lookup_hit;
    logic                 free_frame;
    logic                 out_load;
    logic                 best_valid;
    logic [PAGE_W-1:0]    best_idx;
    scan_ctl_t            scan_ctl;

    assign page_idx_in = PAGE_W'(page);
    assign in_range    = 32'(page) < 32'(NUM_PAGES);
    assign lookup_hit  = resident_reg[page_reg];
    assign free_frame  = frames_given_reg < frame_count_reg;
    assign out_load    = !out_valid_reg || out_ready;

    assign scan_ctl.clear  = (state_reg == S_LOOKUP);
    assign scan_ctl.sample = cmp_valid_reg;

    // Single minimum-count compare unit
    prac_min_scan #(
        .PAGE_W      (PAGE_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .tap_idx      (cmp_idx_reg),
        .tap_count    (cnt_rd_reg),
        .tap_resident (resident_reg[cmp_idx_reg]),
        .best_valid   (best_valid),
        .best_idx     (best_idx)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_range ? S_LOOKUP : S_DONE;
                end
            end
            S_LOOKUP:
            begin
                state_next = (lookup_hit || free_frame) ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_idx_reg == LAST_PAGE)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: state_next = S_VREAD;
            S_VREAD:    state_next = S_EVICT;
            S_EVICT:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        in_ready           = 1'b0;
        frames_given_next  = frames_given_reg;
        fault_total_next   = fault_total_reg;
        resident_next      = resident_reg;
        cmp_valid_next     = 1'b0;
        cmp_idx_next       = cmp_idx_reg;
        scan_idx_next      = scan_idx_reg;
        page_next          = page_reg;
        res_hit_next       = res_hit_reg;
        res_frame_next     = res_frame_reg;
        res_ev_valid_next  = res_ev_valid_reg;
        res_ev_page_next   = res_ev_page_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        hit_next           = hit_reg;
        frame_next         = frame_reg;
        evicted_valid_next = evicted_valid_reg;
        evicted_page_next  = evicted_page_reg;
        faults_next        = faults_reg;
        cnt_ra             = page_reg;
        frm_ra             = page_reg;
        cnt_we             = 1'b0;
        cnt_wd             = COUNT_WIDTH'(1);
        frm_we             = 1'b0;
        frm_wd             = res_frame_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cnt_ra   = page_idx_in;
                frm_ra   = page_idx_in;
                if (in_valid)
                begin
                    page_next         = page_idx_in;
                    res_hit_next      = 1'b0;
                    res_frame_next    = '0;
                    res_ev_valid_next = 1'b0;
                    res_ev_page_next  = '0;
                end
            end
            S_LOOKUP:
            begin
                if (lookup_hit)
                begin
                    // hit: bump counter, saturating
                    res_hit_next   = 1'b1;
                    res_frame_next = frm_rd_reg;
                    cnt_we         = 1'b1;
                    cnt_wd         = (cnt_rd_reg == {COUNT_WIDTH{1'b1}}) ?
                                     cnt_rd_reg : cnt_rd_reg + COUNT_WIDTH'(1);
                end
                else
                begin
                    if (fault_total_reg != FAULT_MAX)
                    begin
                        fault_total_next = fault_total_reg + FAULT_W'(1);
                    end
                    if (free_frame)
                    begin
                        // free frames go out from frame_count downward
                        res_frame_next          = frame_count_reg - frames_given_reg;
                        frm_we                  = 1'b1;
                        frm_wd                  = frame_count_reg - frames_given_reg;
                        cnt_we                  = 1'b1;
                        resident_next[page_reg] = 1'b1;
                        frames_given_next       = frames_given_reg + FRAME_W'(1);
                    end
                    else
                    begin
                        scan_idx_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                // issue one counter read per cycle, compare next cycle
                cnt_ra         = scan_idx_reg;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_idx_reg;
                scan_idx_next  = scan_idx_reg + PAGE_W'(1);
            end
            S_SCAN_END:
            begin
                frm_ra = best_idx;
            end
            S_VREAD:
            begin
                frm_ra = best_idx;
            end
            S_EVICT:
            begin
                // victim frame moves to the new page; no victim gives frame 0
                if (best_valid)
                begin
                    resident_next[best_idx] = 1'b0;
                    res_ev_valid_next       = 1'b1;
                    res_ev_page_next        = PAGE_IN_W'(best_idx);
                    res_frame_next          = frm_rd_reg;
                    frm_wd                  = frm_rd_reg;
                end
                else
                begin
                    res_frame_next = '0;
                    frm_wd         = '0;
                end
                frm_we                  = 1'b1;
                cnt_we                  = 1'b1;
                resident_next[page_reg] = 1'b1;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next     = 1'b1;
                    hit_next           = res_hit_reg;
                    frame_next         = res_frame_reg;
                    evicted_valid_next = res_ev_valid_reg;
                    evicted_page_next  = res_ev_page_reg;
                    faults_next        = fault_total_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_count_reg  <= FRAME_COUNT_RESET;
            frames_given_reg <= '0;
            fault_total_reg  <= '0;
            resident_reg     <= '0;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frames_given_reg <= frames_given_next;
            fault_total_reg  <= fault_total_next;
            resident_reg     <= resident_next;
            cmp_valid_reg    <= cmp_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                frame_count_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        page_reg          <= page_next;
        scan_idx_reg      <= scan_idx_next;
        cmp_idx_reg       <= cmp_idx_next;
        res_hit_reg       <= res_hit_next;
        res_frame_reg     <= res_frame_next;
        res_ev_valid_reg  <= res_ev_valid_next;
        res_ev_page_reg   <= res_ev_page_next;
        hit_reg           <= hit_next;
        frame_reg         <= frame_next;
        evicted_valid_reg <= evicted_valid_next;
        evicted_page_reg  <= evicted_page_next;
        faults_reg        <= faults_next;
    end

    // Count RAM; stale entries of non-resident pages are never used
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[page_reg] <= cnt_wd;
        end
        cnt_rd_reg <= cnt_mem[cnt_ra];
    end

    // Frame RAM
    always_ff @(posedge clk)
    begin
        if (frm_we)
        begin
            frm_mem[page_reg] <= frm_wd;
        end
        frm_rd_reg <= frm_mem[frm_ra];
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame         = frame_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign faults_so_far = faults_reg;

endmodule

// File: sv/prac_checker.sv
module prac_checker
    import prac_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic [FRAME_W-1:0]   frame,
    input logic                 evicted_valid,
    input logic [PAGE_IN_W-1:0] evicted_page,
    input logic [FAULT_W-1:0]   faults_so_far
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(frame) &&
        $stable(evicted_valid) && $stable(evicted_page) && $stable(faults_so_far))
        else $error("result word changed while stalled");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("eviction reported on a hit");

    // No eviction reports page zero
    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted_page nonzero without eviction");

    // One word in flight: busy right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind page_replacement_access_count prac_checker u_prac_checker (.*);

// File: bench/page_replacement_access_count_checker.sv
`timescale 1ns / 100ps

// Watches all three channels of the page replacement block, keeps its own copy
// of the page table and counters, and compares every output word in order.
module page_replacement_access_count_checker
    import prac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [FRAME_W-1:0]   cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [PAGE_IN_W-1:0] page,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 hit,
    input  logic [FRAME_W-1:0]   frame,
    input  logic                 evicted_valid,
    input  logic [PAGE_IN_W-1:0] evicted_page,
    input  logic [FAULT_W-1:0]   faults_so_far,
    output int                   outstanding,
    output int                   errors,
    output int                   words_seen,
    output int                   hits_seen,
    output int                   evictions_seen
);

    localparam int N_PAGES = 16;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame;
        logic                 ev_valid;
        logic [PAGE_IN_W-1:0] ev_page;
        logic [FAULT_W-1:0]   faults;
    } access_word_t;

    // Shadow page table
    bit                 resident   [N_PAGES];
    logic [FRAME_W-1:0] frame_of   [N_PAGES];
    logic [COUNT_W-1:0] access_cnt [N_PAGES];
    logic [FRAME_W-1:0] frames_used;
    logic [FAULT_W-1:0] fault_cnt;
    logic [FRAME_W-1:0] frames_cfg;

    access_word_t access_q[$];

    task automatic report_error(input string msg);
        if (errors < 20)
            $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Apply one page access to the shadow table and build the expected word
    task automatic apply_access(input logic [PAGE_IN_W-1:0] pg, output access_word_t w);
        int victim;
        logic [COUNT_W-1:0] low_cnt;
        victim  = -1;
        low_cnt = '0;
        w = '0;
        if (resident[pg]) begin
            w.hit = 1'b1;
        end
        else begin
            if (fault_cnt != FAULT_MAX)
                fault_cnt++;
            if (frames_used < frames_cfg) begin
                // free frames go out from the top down
                frame_of[pg] = frames_cfg - frames_used;
                frames_used++;
            end
            else begin
                // least used resident page, lowest index on ties
                for (int i = 0; i < N_PAGES; i++) begin
                    if (resident[i] && (victim < 0 || access_cnt[i] < low_cnt)) begin
                        victim  = i;
                        low_cnt = access_cnt[i];
                    end
                end
                if (victim >= 0) begin
                    resident[victim]   = 1'b0;
                    access_cnt[victim] = '0;
                    frame_of[pg]       = frame_of[victim];
                    w.ev_valid         = 1'b1;
                    w.ev_page          = victim[PAGE_IN_W-1:0];
                end
                else begin
                    frame_of[pg] = '0;
                end
            end
            resident[pg] = 1'b1;
        end
        if (access_cnt[pg] != COUNT_SAT)
            access_cnt[pg]++;
        w.frame  = frame_of[pg];
        w.faults = fault_cnt;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        access_word_t want;
        if (!rst_n) begin
            for (int i = 0; i < N_PAGES; i++) begin
                resident[i]   = 1'b0;
                frame_of[i]   = '0;
                access_cnt[i] = '0;
            end
            frames_used = '0;
            fault_cnt   = '0;
            frames_cfg  = FRAME_COUNT_RESET;
            access_q.delete();
            outstanding    <= 0;
            errors         = 0;
            words_seen     = 0;
            hits_seen      = 0;
            evictions_seen = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                frames_cfg = cfg_data;

            // compare the output word against the oldest expectation
            if (out_valid && out_ready) begin
                words_seen++;
                if (access_q.size() == 0) begin
                    report_error("output word with nothing expected");
                end
                else begin
                    want = access_q.pop_front();
                    if (hit !== want.hit)
                        report_error($sformatf("hit got %0d exp %0d", hit, want.hit));
                    if (frame !== want.frame)
                        report_error($sformatf("frame got %0d exp %0d", frame, want.frame));
                    if (evicted_valid !== want.ev_valid)
                        report_error($sformatf("evicted_valid got %0d exp %0d",
                                               evicted_valid, want.ev_valid));
                    if (evicted_page !== want.ev_page)
                        report_error($sformatf("evicted_page got %0d exp %0d",
                                               evicted_page, want.ev_page));
                    if (faults_so_far !== want.faults)
                        report_error($sformatf("faults_so_far got %0d exp %0d",
                                               faults_so_far, want.faults));
                    if (want.hit)
                        hits_seen++;
                    if (want.ev_valid)
                        evictions_seen++;
                end
            end

            if (in_valid && in_ready) begin
                apply_access(page, want);
                access_q.push_back(want);
            end

            outstanding <= access_q.size();
        end
    end

endmodule

// File: bench/page_replacement_access_count_tb.sv
`timescale 1ns / 100ps

module page_replacement_access_count_tb;
    import prac_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [FRAME_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [PAGE_IN_W-1:0] page;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic                 evicted_valid;
    logic [PAGE_IN_W-1:0] evicted_page;
    logic [FAULT_W-1:0]   faults_so_far;

    int outstanding;
    int errors;
    int words_seen;
    int hits_seen;
    int evictions_seen;

    logic squeeze_req;
    int   pages_sent;
    int   cfg_writes;

    page_replacement_access_count u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page          (page),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .frame         (frame),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .faults_so_far (faults_so_far)
    );

    page_replacement_access_count_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .page           (page),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .frame          (frame),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .faults_so_far  (faults_so_far),
        .outstanding    (outstanding),
        .errors         (errors),
        .words_seen     (words_seen),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Offer one page and hold it until it is taken
    task automatic send_page(input logic [PAGE_IN_W-1:0] p);
        in_valid <= 1'b1;
        page     <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pages_sent++;
    endtask

    // Drain the block, then write frame_count
    task automatic set_frames(input logic [FRAME_W-1:0] fc);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= fc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Random traffic, mostly in a working set of the pool size plus up to 3, at most 16
    task automatic run_segment(input int n_items, input logic [FRAME_W-1:0] fc,
                               input bit squeeze);
        int sent;
        int burst;
        int gap;
        int ws;
        int base;
        sent = 0;
        set_frames(fc);
        ws = (fc == 0) ? 2 : int'(fc) + $urandom_range(0, 3);
        if (ws > 16)
            ws = 16;
        base = $urandom_range(0, 15);
        if (squeeze)
            squeeze_req <= 1'b1;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0)
                base = $urandom_range(0, 15);
            repeat (burst) begin
                if ($urandom_range(0, 3) != 0)
                    send_page(PAGE_IN_W'((base + $urandom_range(0, ws - 1)) % 16));
                else
                    send_page(PAGE_IN_W'($urandom_range(0, 15)));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Receiver: stall duty changes from span to span, one long hold on request
    initial
    begin
        int  span;
        int  stall_pct;
        bit  squeezed;
        squeezed  = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (squeeze_req && !squeezed) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                squeezed = 1'b1;
            end
            span = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (span) begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        in_valid    = 1'b0;
        page        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        squeeze_req = 1'b0;
        pages_sent  = 0;
        cfg_writes  = 0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no frames at all: first miss lands in frame 0, next one evicts it
        set_frames(5'd0);
        send_page(4'd0);
        send_page(4'd15);
        send_page(4'd15);

        // two frames, then eviction of the least-counted resident page
        set_frames(5'd2);
        send_page(4'd3);
        send_page(4'd3);
        send_page(4'd7);
        send_page(4'd9);
        send_page(4'd3);
        send_page(4'd12);
        send_page(4'd4);
        send_page(4'd5);

        // pool above the page count: frames numbered from the top
        set_frames(5'd31);
        send_page(4'd1);
        send_page(4'd2);
        send_page(4'd8);
        send_page(4'd2);

        // shrink the pool below what is already handed out: no eviction by itself
        set_frames(5'd1);
        send_page(4'd1);
        send_page(4'd6);
        send_page(4'd13);

        // one page hit many times in a row, back to back
        set_frames(5'd16);
        repeat (40) send_page(4'd11);

        // random phases across frame pool sizes
        run_segment(80, 5'd3, 1'b0);
        run_segment(80, 5'd2, 1'b1);
        run_segment(80, 5'd0, 1'b0);
        run_segment(80, 5'd16, 1'b0);
        run_segment(80, 5'd1, 1'b0);
        run_segment(80, 5'd31, 1'b0);
        run_segment(80, FRAME_W'($urandom_range(1, 16)), 1'b0);
        run_segment(60, FRAME_COUNT_RESET, 1'b0);

        // drain and let the slowest eviction settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Covered %0d page accesses (%0d hits, %0d evictions)",
                 pages_sent, hits_seen, evictions_seen);
        $display("over %0d frame pool settings, including an empty pool and a long hold-off.",
                 cfg_writes);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

endmodule
